>>> src/one_wire_temperature_reader_defines.svh
// ----------------------------------------------------------------------------
// one-wire temperature reader assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH

// cause and effect in the same cycle
`define OWTR_ASSERT_SAME(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);

// effect in the cycle after the cause
`define OWTR_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

>>> src/owtr_pkg.sv
// ----------------------------------------------------------------------------
// owtr_pkg
// types, codes and constants shared by the one-wire temperature reader
// ----------------------------------------------------------------------------
package owtr_pkg;

   // request op codes
   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_RESET = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_TEMP  = 3'd4
   } op_type;

   // classified start request carried through the queue
   typedef enum logic [2:0] {
      START_NONE,
      START_RESET,
      START_WRITE,
      START_READ,
      START_TEMP
   } start_type;

   // bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_REC  = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_WR_HIGH  = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_REC   = 4'd8
   } phase_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_RESET_LOW      = 3'd0,
      CSR_PRESENCE_SAMPLE = 3'd1,
      CSR_RESET_RECOVERY = 3'd2,
      CSR_WRITE_SHORT    = 3'd3,
      CSR_WRITE_LONG     = 3'd4,
      CSR_READ_LOW       = 3'd5,
      CSR_READ_SAMPLE    = 3'd6,
      CSR_READ_RECOVERY  = 3'd7
   } csr_index_type;

   localparam int CSR_DATA_WIDTH = 10;
   localparam int DUR_WIDTH      = 10;

   // temperature sequence steps
   localparam logic [3:0] STEP_FIRST_RESET  = 4'd0;
   localparam logic [3:0] STEP_SKIP_ROM_A   = 4'd1;
   localparam logic [3:0] STEP_CONVERT      = 4'd2;
   localparam logic [3:0] STEP_SECOND_RESET = 4'd3;
   localparam logic [3:0] STEP_SKIP_ROM_B   = 4'd4;
   localparam logic [3:0] STEP_READ_SCRATCH = 4'd5;
   localparam logic [3:0] STEP_READ_LOW     = 4'd6;
   localparam logic [3:0] STEP_READ_HIGH    = 4'd7;
   localparam logic [3:0] STEP_SINGLE       = 4'd8;

   // one-wire command bytes
   localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
   localparam logic [7:0] CMD_CONVERT      = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [9:0] reset_low_us;
      logic [7:0] presence_sample_us;
      logic [9:0] reset_recovery_us;
      logic [3:0] write_short_us;
      logic [7:0] write_long_us;
      logic [3:0] read_low_us;
      logic [3:0] read_sample_us;
      logic [7:0] read_recovery_us;
   } cfg_type;

   typedef struct packed {
      start_type  start;
      logic [7:0] data_byte;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic        pin_output;
      logic        pin_level;
      logic        busy_res;
      logic        done_res;
      logic        no_presence;
      logic [7:0]  byte_read;
      logic [15:0] temp_raw;
      logic [6:0]  temp_whole;
   } result_type;

endpackage

>>> src/owtr_front.sv
// ----------------------------------------------------------------------------
// owtr_front
// accepts tick transactions, classifies the op and queues the items
// ----------------------------------------------------------------------------
module owtr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_data_byte,
   input  logic              req_line_level,
   output logic              q_valid,
   input  logic              q_pop,
   output owtr_pkg::item_type q_item
);
   import owtr_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR   = PTR_WIDTH'(QUEUE_DEPTH - 1);

   item_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   item_type             new_item;
   logic                 push;

   // unknown codes behave as a plain tick
   always_comb begin
      new_item.data_byte  = req_data_byte;
      new_item.line_level = req_line_level;
      unique case (req_op)
         OP_RESET: new_item.start = START_RESET;
         OP_WRITE: new_item.start = START_WRITE;
         OP_READ:  new_item.start = START_READ;
         OP_TEMP:  new_item.start = START_TEMP;
         default:  new_item.start = START_NONE;
      endcase
   end

   assign req_stall = (count_ff == FULL_COUNT);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> src/owtr_seq.sv
// ----------------------------------------------------------------------------
// owtr_seq
// bus sequencer: advances one microsecond per queued item, registers result
// ----------------------------------------------------------------------------
`include "one_wire_temperature_reader_defines.svh"

module owtr_seq #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  owtr_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  owtr_pkg::item_type   q_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output owtr_pkg::result_type rsp_result
);
   import owtr_pkg::*;

   localparam int LEN_WIDTH = (COUNT_WIDTH > DUR_WIDTH) ? COUNT_WIDTH : DUR_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] us_counter_ff, us_counter_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [3:0]             step_ff, step_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             low_ff, low_in;
   logic [7:0]             high_ff, high_in;
   logic                   presence_missing_ff, presence_missing_in;
   logic [7:0]             last_read_ff, last_read_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   logic [DUR_WIDTH-1:0]   dur_raw;
   logic [LEN_WIDTH-1:0]   dur_len;
   logic                   bit_one;
   logic                   drive, level, done;
   logic                   fin, fin_read;
   logic [3:0]             next_step;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in            = phase_ff;
      us_counter_in       = us_counter_ff;
      bit_index_in        = bit_index_ff;
      step_in             = step_ff;
      shift_in            = shift_ff;
      low_in              = low_ff;
      high_in             = high_ff;
      presence_missing_in = presence_missing_ff;
      last_read_in        = last_read_ff;
      drive               = 1'b0;
      level               = 1'b1;
      done                = 1'b0;
      fin                 = 1'b0;
      fin_read            = 1'b0;
      next_step           = '0;
      dur_raw             = '0;
      dur_len             = '0;
      bit_one             = 1'b0;

      // a start is taken only while idle
      if (phase_ff == PH_IDLE) begin
         case (q_item.start)
            START_TEMP: begin
               step_in       = STEP_FIRST_RESET;
               phase_in      = PH_RST_LOW;
               us_counter_in = '0;
            end
            START_RESET: begin
               step_in       = STEP_SINGLE;
               phase_in      = PH_RST_LOW;
               us_counter_in = '0;
            end
            START_WRITE: begin
               step_in       = STEP_SINGLE;
               shift_in      = q_item.data_byte;
               bit_index_in  = '0;
               phase_in      = PH_WR_LOW;
               us_counter_in = '0;
            end
            START_READ: begin
               step_in       = STEP_SINGLE;
               shift_in      = '0;
               bit_index_in  = '0;
               phase_in      = PH_RD_LOW;
               us_counter_in = '0;
            end
            default: ;
         endcase
      end

      // phase length with zero and counter-range saturation
      bit_one = shift_in[0];
      case (phase_in)
         PH_RST_LOW:  dur_raw = cfg.reset_low_us;
         PH_RST_WAIT: dur_raw = DUR_WIDTH'(cfg.presence_sample_us);
         PH_RST_REC:  dur_raw = cfg.reset_recovery_us;
         PH_WR_LOW:   dur_raw = bit_one ? DUR_WIDTH'(cfg.write_short_us)
                                        : DUR_WIDTH'(cfg.write_long_us);
         PH_WR_HIGH:  dur_raw = bit_one ? DUR_WIDTH'(cfg.write_long_us)
                                        : DUR_WIDTH'(cfg.write_short_us);
         PH_RD_LOW:   dur_raw = DUR_WIDTH'(cfg.read_low_us);
         PH_RD_WAIT:  dur_raw = DUR_WIDTH'(cfg.read_sample_us);
         default:     dur_raw = DUR_WIDTH'(cfg.read_recovery_us);
      endcase
      dur_len = LEN_WIDTH'(dur_raw);
      if (dur_len == '0) begin
         dur_len = LEN_WIDTH'(1);
      end else if (dur_len > LEN_WIDTH'(CNT_MAX)) begin
         dur_len = LEN_WIDTH'(CNT_MAX);
      end

      if (phase_in != PH_IDLE) begin
         case (phase_in)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: begin
               drive = 1'b1;
               level = 1'b0;
            end
            PH_RST_REC, PH_WR_HIGH: begin
               drive = 1'b1;
               level = 1'b1;
            end
            default: ;
         endcase
         us_counter_in = us_counter_in + 1'b1;
         if (LEN_WIDTH'(us_counter_in) >= dur_len) begin
            us_counter_in = '0;
            case (phase_in)
               PH_RST_LOW:  phase_in = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  presence_missing_in = q_item.line_level;
                  phase_in            = PH_RST_REC;
               end
               PH_RST_REC:  fin = 1'b1;
               PH_WR_LOW:   phase_in = PH_WR_HIGH;
               PH_WR_HIGH: begin
                  if (bit_index_in == 3'd7) begin
                     fin = 1'b1;
                  end else begin
                     bit_index_in = bit_index_in + 1'b1;
                     shift_in     = {1'b0, shift_in[7:1]};
                     phase_in     = PH_WR_LOW;
                  end
               end
               PH_RD_LOW:   phase_in = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  shift_in = {q_item.line_level, shift_in[7:1]};
                  phase_in = PH_RD_REC;
               end
               default: begin
                  if (bit_index_in == 3'd7) begin
                     fin      = 1'b1;
                     fin_read = 1'b1;
                  end else begin
                     bit_index_in = bit_index_in + 1'b1;
                     phase_in     = PH_RD_LOW;
                  end
               end
            endcase
         end
      end

      // end of one sub-operation: store a read byte, then next step or done
      if (fin) begin
         if (fin_read) begin
            last_read_in = shift_in;
            if (step_in == STEP_READ_LOW) low_in = shift_in;
            if (step_in == STEP_READ_HIGH) high_in = shift_in;
         end
         if (step_in >= STEP_READ_HIGH) begin
            phase_in      = PH_IDLE;
            us_counter_in = '0;
            done          = 1'b1;
         end else begin
            next_step = step_in + 1'b1;
            // no device answered: skip the command bytes after that reset
            if (presence_missing_in &&
                (next_step == STEP_SKIP_ROM_A || next_step == STEP_SKIP_ROM_B)) begin
               next_step = next_step + 4'd2;
            end
            step_in       = next_step;
            us_counter_in = '0;
            bit_index_in  = '0;
            case (next_step)
               STEP_FIRST_RESET, STEP_SECOND_RESET: phase_in = PH_RST_LOW;
               STEP_SKIP_ROM_A, STEP_SKIP_ROM_B: begin
                  shift_in = CMD_SKIP_ROM;
                  phase_in = PH_WR_LOW;
               end
               STEP_CONVERT: begin
                  shift_in = CMD_CONVERT;
                  phase_in = PH_WR_LOW;
               end
               STEP_READ_SCRATCH: begin
                  shift_in = CMD_READ_SCRATCH;
                  phase_in = PH_WR_LOW;
               end
               default: begin
                  shift_in = '0;
                  phase_in = PH_RD_LOW;
               end
            endcase
         end
      end

      rsp_in.pin_output  = drive;
      rsp_in.pin_level   = level;
      rsp_in.busy_res    = (phase_in != PH_IDLE);
      rsp_in.done_res    = done;
      rsp_in.no_presence = presence_missing_in;
      rsp_in.byte_read   = last_read_in;
      rsp_in.temp_raw    = {high_in, low_in};
      rsp_in.temp_whole  = {high_in[2:0], low_in[7:4]};
   end

   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         us_counter_ff       <= '0;
         bit_index_ff        <= '0;
         step_ff             <= '0;
         shift_ff            <= '0;
         low_ff              <= '0;
         high_ff             <= '0;
         presence_missing_ff <= 1'b0;
         last_read_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff            <= phase_in;
            us_counter_ff       <= us_counter_in;
            bit_index_ff        <= bit_index_in;
            step_ff             <= step_in;
            shift_ff            <= shift_in;
            low_ff              <= low_in;
            high_ff             <= high_in;
            presence_missing_ff <= presence_missing_in;
            last_read_ff        <= last_read_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   `OWTR_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_ff.done_res,
      !rsp_ff.busy_res, "done result still reports busy")
   `OWTR_ASSERT_SAME(a_idle_counter_clear, clock, reset, phase_ff == PH_IDLE,
      us_counter_ff == '0, "idle sequencer with running counter")
   `OWTR_ASSERT_NEXT(a_pop_loads_result, clock, reset, q_pop,
      rsp_valid_ff && (rsp_ff.busy_res == (phase_ff != PH_IDLE)),
      "result busy flag disagrees with sequencer phase")
   `OWTR_ASSERT_SAME(a_release_level_high, clock, reset,
      rsp_valid_ff && !rsp_ff.pin_output, rsp_ff.pin_level,
      "released pin reports low drive level")

endmodule

>>> src/one_wire_temperature_reader.sv
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// one-wire bus master with a temperature-read sequencer, one tick per item
// ----------------------------------------------------------------------------
// an accepted tick is stored in the front queue and its result in the result
// register; both wait longer while the result side stalls
// throughput: one transaction per cycle while the result side does not stall, as the
// sequencer update advances the phase counter once per queued tick
// reset: synchronous, clears the queue, the sequencer and the result valid flag
// and returns every timing register to its default
module one_wire_temperature_reader #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick transactions in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_op,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_line_level,
   // one result transaction per tick out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pin_output,
   output logic                                rsp_pin_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_no_presence,
   output logic [7:0]                          rsp_byte_read,
   output logic [15:0]                         rsp_temp_raw,
   output logic [6:0]                          rsp_temp_whole,
   // timing register writes
   input  logic                                csr_write_enable,
   input  logic [2:0]                          csr_index,
   input  logic [owtr_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import owtr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_valid;
   logic       q_pop;
   item_type   q_item;
   result_type rsp_result;

   // register writes, each field keeps only its own width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RESET_LOW:       cfg_in.reset_low_us       = csr_write_data;
            CSR_PRESENCE_SAMPLE: cfg_in.presence_sample_us = csr_write_data[7:0];
            CSR_RESET_RECOVERY:  cfg_in.reset_recovery_us  = csr_write_data;
            CSR_WRITE_SHORT:     cfg_in.write_short_us     = csr_write_data[3:0];
            CSR_WRITE_LONG:      cfg_in.write_long_us      = csr_write_data[7:0];
            CSR_READ_LOW:        cfg_in.read_low_us        = csr_write_data[3:0];
            CSR_READ_SAMPLE:     cfg_in.read_sample_us     = csr_write_data[3:0];
            CSR_READ_RECOVERY:   cfg_in.read_recovery_us   = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // defaults are standard-speed slot timings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us       <= 10'd750;
         cfg_ff.presence_sample_us <= 8'd60;
         cfg_ff.reset_recovery_us  <= 10'd240;
         cfg_ff.write_short_us     <= 4'd6;
         cfg_ff.write_long_us      <= 8'd60;
         cfg_ff.read_low_us        <= 4'd3;
         cfg_ff.read_sample_us     <= 4'd3;
         cfg_ff.read_recovery_us   <= 8'd30;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, classify, queue
   owtr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_line_level (req_line_level),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (q_item)
   );

   // back: bus sequencer and result register
   owtr_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // result fields out
   assign rsp_pin_output  = rsp_result.pin_output;
   assign rsp_pin_level   = rsp_result.pin_level;
   assign rsp_busy_res    = rsp_result.busy_res;
   assign rsp_done_res    = rsp_result.done_res;
   assign rsp_no_presence = rsp_result.no_presence;
   assign rsp_byte_read   = rsp_result.byte_read;
   assign rsp_temp_raw    = rsp_result.temp_raw;
   assign rsp_temp_whole  = rsp_result.temp_whole;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the one-wire temperature reader: tick transactions
// are driven through the request channel while an in-bench sequencer model
// and a simple emulated bus device predict every result transaction, which
// is checked field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb_top;
   import owtr_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_LIMIT  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 100;
   localparam int COUNT_WIDTH   = 10;
   localparam int COUNT_MAX     = (1 << COUNT_WIDTH) - 1;

   // op values outside the defined set behave as a plain tick
   localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;
   localparam logic [2:0] LAST_BIT         = 3'd7;

   // receiver behavior on the result channel
   typedef enum int {
      RX_READY,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_op = OP_TICK;
   logic [7:0]                req_data_byte = '0;
   logic                      req_line_level = 1'b1;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_pin_output;
   logic                      rsp_pin_level;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic                      rsp_no_presence;
   logic [7:0]                rsp_byte_read;
   logic [15:0]               rsp_temp_raw;
   logic [6:0]                rsp_temp_whole;
   logic                      csr_write_enable = 1'b0;
   logic [2:0]                csr_index = CSR_RESET_LOW;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   // sequencer model state
   cfg_type                   timing;
   phase_type                 ph;
   logic [COUNT_WIDTH-1:0]    tick_count;
   logic [2:0]                bit_idx;
   logic [3:0]                seq_step;
   logic [7:0]                shreg;
   logic [7:0]                temp_lo;
   logic [7:0]                temp_hi;
   logic [7:0]                last_byte;
   logic                      no_answer;

   // emulated device: answers resets and returns two bytes on reads
   logic                      dev_present;
   logic [7:0]                dev_low;
   logic [7:0]                dev_high;
   bit                        line_noise = 1'b0;

   result_type                expected_ticks[$];
   int                        fail_count = 0;
   int                        items_sent = 0;
   int                        cycle_count = 0;

   // sender burst shaping and receiver stall control
   bit                        gaps_on = 1'b0;
   int                        burst_left = 0;
   rx_mode_type               rx_mode = RX_READY;
   int                        hold_request = 0;
   int                        hold_left = 0;
   int                        stall_phase = 0;

   one_wire_temperature_reader #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .req_line_level  (req_line_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pin_output  (rsp_pin_output),
      .rsp_pin_level   (rsp_pin_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_no_presence (rsp_no_presence),
      .rsp_byte_read   (rsp_byte_read),
      .rsp_temp_raw    (rsp_temp_raw),
      .rsp_temp_whole  (rsp_temp_whole),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // sequencer model
   // ---------------------------------------------------------------------

   function automatic void init_model();
      timing.reset_low_us       = 10'd750;
      timing.presence_sample_us = 8'd60;
      timing.reset_recovery_us  = 10'd240;
      timing.write_short_us     = 4'd6;
      timing.write_long_us      = 8'd60;
      timing.read_low_us        = 4'd3;
      timing.read_sample_us     = 4'd3;
      timing.read_recovery_us   = 8'd30;
      ph         = PH_IDLE;
      tick_count = '0;
      bit_idx    = '0;
      seq_step   = STEP_FIRST_RESET;
      shreg      = '0;
      temp_lo    = '0;
      temp_hi    = '0;
      last_byte  = '0;
      no_answer  = 1'b0;
   endfunction

   function automatic void open_reset();
      ph         = PH_RST_LOW;
      tick_count = '0;
   endfunction

   function automatic void open_write(input logic [7:0] value);
      shreg      = value;
      bit_idx    = '0;
      ph         = PH_WR_LOW;
      tick_count = '0;
   endfunction

   function automatic void open_read();
      shreg      = '0;
      bit_idx    = '0;
      ph         = PH_RD_LOW;
      tick_count = '0;
   endfunction

   // ticks spent in the current phase; a write bit's split depends on its value
   function automatic int slot_length();
      int len;
      case (ph)
         PH_RST_LOW:  len = int'(timing.reset_low_us);
         PH_RST_WAIT: len = int'(timing.presence_sample_us);
         PH_RST_REC:  len = int'(timing.reset_recovery_us);
         PH_WR_LOW:   len = shreg[0] ? int'(timing.write_short_us)
                                     : int'(timing.write_long_us);
         PH_WR_HIGH:  len = shreg[0] ? int'(timing.write_long_us)
                                     : int'(timing.write_short_us);
         PH_RD_LOW:   len = int'(timing.read_low_us);
         PH_RD_WAIT:  len = int'(timing.read_sample_us);
         default:     len = int'(timing.read_recovery_us);
      endcase
      if (len == 0) len = 1;
      if (len > COUNT_MAX) len = COUNT_MAX;
      return len;
   endfunction

   // end of one bus operation; moves the temperature sequence on, returns done
   function automatic logic close_step(input logic was_read);
      logic [3:0] nxt;
      nxt = seq_step;
      if (was_read) begin
         last_byte = shreg;
         if (nxt == STEP_READ_LOW) temp_lo = shreg;
         if (nxt == STEP_READ_HIGH) temp_hi = shreg;
      end
      if (nxt >= STEP_READ_HIGH) begin
         ph         = PH_IDLE;
         tick_count = '0;
         return 1'b1;
      end
      nxt = nxt + 1'b1;
      // no device answered: skip both command bytes after that reset
      if (no_answer && (nxt == STEP_SKIP_ROM_A || nxt == STEP_SKIP_ROM_B))
         nxt = nxt + 4'd2;
      seq_step = nxt;
      case (nxt)
         STEP_FIRST_RESET, STEP_SECOND_RESET: open_reset();
         STEP_SKIP_ROM_A, STEP_SKIP_ROM_B:    open_write(CMD_SKIP_ROM);
         STEP_CONVERT:                        open_write(CMD_CONVERT);
         STEP_READ_SCRATCH:                   open_write(CMD_READ_SCRATCH);
         default:                             open_read();
      endcase
      return 1'b0;
   endfunction

   // one microsecond tick: returns the result transaction it produces
   function automatic result_type predict_tick(input logic [2:0] op, input logic [7:0] data,
                                               input logic line);
      result_type r;
      logic       drive;
      logic       level;
      logic       fin;
      drive = 1'b0;
      level = 1'b1;
      fin   = 1'b0;
      // a start while busy is dropped
      if (ph == PH_IDLE && op >= OP_RESET && op <= OP_TEMP) begin
         if (op == OP_TEMP) begin
            seq_step = STEP_FIRST_RESET;
            open_reset();
         end else begin
            seq_step = STEP_SINGLE;
            case (op)
               OP_RESET: open_reset();
               OP_WRITE: open_write(data);
               default:  open_read();
            endcase
         end
      end
      if (ph != PH_IDLE) begin
         case (ph)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: begin
               drive = 1'b1;
               level = 1'b0;
            end
            PH_RST_REC, PH_WR_HIGH: begin
               drive = 1'b1;
               level = 1'b1;
            end
            default: ;
         endcase
         tick_count = tick_count + 1'b1;
         if (int'(tick_count) >= slot_length()) begin
            tick_count = '0;
            case (ph)
               PH_RST_LOW: ph = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  no_answer = line;
                  ph        = PH_RST_REC;
               end
               PH_RST_REC: fin = close_step(1'b0);
               PH_WR_LOW:  ph = PH_WR_HIGH;
               PH_WR_HIGH: begin
                  if (bit_idx == LAST_BIT) begin
                     fin = close_step(1'b0);
                  end else begin
                     bit_idx = bit_idx + 1'b1;
                     shreg   = shreg >> 1;
                     ph      = PH_WR_LOW;
                  end
               end
               PH_RD_LOW: ph = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  shreg = {line, shreg[7:1]};
                  ph    = PH_RD_REC;
               end
               default: begin
                  if (bit_idx == LAST_BIT) begin
                     fin = close_step(1'b1);
                  end else begin
                     bit_idx = bit_idx + 1'b1;
                     ph      = PH_RD_LOW;
                  end
               end
            endcase
         end
      end
      r.pin_output  = drive;
      r.pin_level   = level;
      r.busy_res    = (ph != PH_IDLE);
      r.done_res    = fin;
      r.no_presence = no_answer;
      r.byte_read   = last_byte;
      r.temp_raw    = {temp_hi, temp_lo};
      r.temp_whole  = {temp_hi[2:0], 4'b0000} + {3'b000, temp_lo[7:4]};
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // emulated device and item choice
   // ---------------------------------------------------------------------

   // line level the device shows for the tick about to be sent
   function automatic logic bus_level();
      if (line_noise && $urandom_range(0, 15) == 0) return 1'($urandom_range(0, 1));
      case (ph)
         PH_RST_WAIT: return !dev_present;
         PH_RD_WAIT:  return (seq_step == STEP_READ_HIGH) ? dev_high[bit_idx] : dev_low[bit_idx];
         default:     return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // ops offered while busy: mostly plain ticks, some starts that must be dropped
   function automatic logic [2:0] noise_op();
      if ($urandom_range(0, 3) == 0) return 3'($urandom_range(OP_TICK, OP_UNKNOWN_LAST));
      return OP_TICK;
   endfunction

   function automatic logic [2:0] pick_op();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return OP_TEMP;
         4:          return OP_RESET;
         5:          return OP_WRITE;
         6:          return OP_READ;
         7:          return OP_TICK;
         default:    return 3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
      endcase
   endfunction

   // short timings so that whole temperature sequences fit in the run
   function automatic cfg_type quick_timing(input int top);
      cfg_type c;
      c.reset_low_us       = 10'($urandom_range(0, top));
      c.presence_sample_us = 8'($urandom_range(0, top));
      c.reset_recovery_us  = 10'($urandom_range(0, top));
      c.write_short_us     = 4'($urandom_range(0, top));
      c.write_long_us      = 8'($urandom_range(0, top));
      c.read_low_us        = 4'($urandom_range(0, top));
      c.read_sample_us     = 4'($urandom_range(0, top));
      c.read_recovery_us   = 8'($urandom_range(0, top));
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // offer one tick transaction and hold it until accepted
   task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic line);
      req_valid      <= 1'b1;
      req_op         <= op;
      req_data_byte  <= data;
      req_line_level <= line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_ticks.push_back(predict_tick(op, data, line));
      items_sent++;
      // bursts of random length separated by random gaps
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
   endtask

   // start an op and keep ticking until the sequencer is idle again
   task automatic run_op(input logic [2:0] op, input logic [7:0] data, input logic present,
                         input logic [7:0] low, input logic [7:0] high);
      dev_present = present;
      dev_low     = low;
      dev_high    = high;
      send_tick(op, data, bus_level());
      while (ph != PH_IDLE) send_tick(noise_op(), 8'($urandom), bus_level());
   endtask

   // finish any running op, stop offering and let every result come back
   task automatic wait_idle();
      while (ph != PH_IDLE) send_tick(OP_TICK, 8'($urandom), bus_level());
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
   endtask

   // write all eight timing registers; spare upper data bits carry noise
   task automatic load_timing(input cfg_type c);
      logic [CSR_DATA_WIDTH-1:0] word;
      csr_index_type             idx;
      wait_idle();
      for (int i = 0; i <= CSR_READ_RECOVERY; i++) begin
         idx  = csr_index_type'(i);
         word = CSR_DATA_WIDTH'($urandom);
         case (idx)
            CSR_RESET_LOW: begin
               word                = c.reset_low_us;
               timing.reset_low_us = word;
            end
            CSR_PRESENCE_SAMPLE: begin
               word[7:0]                 = c.presence_sample_us;
               timing.presence_sample_us = word[7:0];
            end
            CSR_RESET_RECOVERY: begin
               word                     = c.reset_recovery_us;
               timing.reset_recovery_us = word;
            end
            CSR_WRITE_SHORT: begin
               word[3:0]             = c.write_short_us;
               timing.write_short_us = word[3:0];
            end
            CSR_WRITE_LONG: begin
               word[7:0]            = c.write_long_us;
               timing.write_long_us = word[7:0];
            end
            CSR_READ_LOW: begin
               word[3:0]          = c.read_low_us;
               timing.read_low_us = word[3:0];
            end
            CSR_READ_SAMPLE: begin
               word[3:0]             = c.read_sample_us;
               timing.read_sample_us = word[3:0];
            end
            default: begin
               word[7:0]               = c.read_recovery_us;
               timing.read_recovery_us = word[7:0];
            end
         endcase
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= word;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // random ops with random device content until enough transactions went in
   task automatic run_traffic(input int count);
      int first;
      first = items_sent;
      while (items_sent - first < count)
         run_op(pick_op(), 8'($urandom), $urandom_range(0, 4) != 0, 8'($urandom),
                8'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // registers untouched since reset: a plain tick, then a byte read at default slot timing
   task automatic test_default_timing();
      gaps_on = 1'b1;
      rx_mode = RX_LIGHT;
      run_op(OP_TICK, 8'hFF, 1'b1, 8'h00, 8'h00);
      run_op(OP_READ, 8'h00, 1'b1, 8'h96, 8'h00);
   endtask

   // every duration zero, so each phase lasts one tick
   task automatic test_zero_timing();
      load_timing('0);
      gaps_on = 1'b1;
      rx_mode = RX_PERIODIC;
      // unknown ops act as plain ticks
      run_op(OP_UNKNOWN_FIRST, 8'h00, 1'b1, 8'h00, 8'h00);
      run_op(OP_UNKNOWN_LAST, 8'hFF, 1'b1, 8'h00, 8'h00);
      // bus reset with and without a device answering
      run_op(OP_RESET, 8'h00, 1'b0, 8'h00, 8'h00);
      run_op(OP_RESET, 8'h00, 1'b1, 8'h00, 8'h00);
      // single write goes out with no presence check
      run_op(OP_WRITE, 8'hFF, 1'b0, 8'h00, 8'h00);
      run_op(OP_WRITE, 8'h00, 1'b0, 8'h00, 8'h00);
      run_op(OP_READ, 8'h00, 1'b1, 8'hFF, 8'h00);
      run_op(OP_READ, 8'h00, 1'b1, 8'hA5, 8'h00);
      // temperature extremes, then a missing device that skips the commands
      run_op(OP_TEMP, 8'h00, 1'b1, 8'hFF, 8'hFF);
      run_op(OP_TEMP, 8'h00, 1'b1, 8'h91, 8'h01);
      run_op(OP_TEMP, 8'hFF, 1'b0, 8'h00, 8'h00);
   endtask

   // every register at its top value: a full-length bus reset
   task automatic test_long_timing();
      load_timing('{10'd1023, 8'd255, 10'd1023, 4'd15, 8'd255, 4'd15, 4'd15, 8'd255});
      gaps_on = 1'b0;
      rx_mode = RX_READY;
      run_op(OP_RESET, 8'h00, 1'b1, 8'h00, 8'h00);
   endtask

   // several short timing sets, each with its own idle pattern
   task automatic test_random_traffic();
      line_noise = 1'b1;
      for (int p = 0; p < 4; p++) begin
         load_timing(quick_timing((p == 3) ? 6 : p + 1));
         gaps_on = (p != 0);
         rx_mode = rx_mode_type'(p);
         run_traffic(PHASE_ITEMS);
      end
      line_noise = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering, so the block fills up
   task automatic test_backpressure();
      wait_idle();
      gaps_on      = 1'b0;
      rx_mode      = RX_READY;
      hold_request = HOLD_CYCLES;
      run_traffic(80);
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   // stall pattern of the receiver, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase++;
         case (rx_mode)
            RX_READY: rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:  rsp_stall <= ((stall_phase % 8) < 3);
         endcase
      end
   end

   function automatic string describe(input result_type r);
      return $sformatf("drive %b level %b busy %b done %b nopres %b byte %h raw %h whole %0d",
                       r.pin_output, r.pin_level, r.busy_res, r.done_res, r.no_presence,
                       r.byte_read, r.temp_raw, r.temp_whole);
   endfunction

   // compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.pin_output  = rsp_pin_output;
         seen.pin_level   = rsp_pin_level;
         seen.busy_res    = rsp_busy_res;
         seen.done_res    = rsp_done_res;
         seen.no_presence = rsp_no_presence;
         seen.byte_read   = rsp_byte_read;
         seen.temp_raw    = rsp_temp_raw;
         seen.temp_whole  = rsp_temp_whole;
         if (expected_ticks.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result transaction: %s", describe(seen));
         end else begin
            want = expected_ticks.pop_front();
            if (seen.pin_output !== want.pin_output || seen.pin_level !== want.pin_level ||
                seen.busy_res !== want.busy_res || seen.done_res !== want.done_res ||
                seen.no_presence !== want.no_presence || seen.byte_read !== want.byte_read ||
                seen.temp_raw !== want.temp_raw || seen.temp_whole !== want.temp_whole) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("result mismatch at cycle %0d", cycle_count);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(seen));
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      init_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_zero_timing();
      test_long_timing();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      // let any stray result transaction show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_ticks.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
